>>> rtl/core/gtp_pkg.sv
`default_nettype none
package gtp_pkg;

    localparam int CORDIC_STEPS = 18;
    // vector lane width: covers the largest prerotated input plus CORDIC gain
    localparam int VEC_W  = 37;
    // angle width in Q30 radians: pi plus the full arctangent sum
    localparam int ANG_W  = 35;
    // operand width at the CORDIC input
    localparam int NUM_W  = 34;
    // front stages, CORDIC prerotation, iterations, two output stages
    localparam int LATENCY = CORDIC_STEPS + 6;

    localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

    typedef enum logic [2:0] {
        REG_TARGET_X        = 3'd0,
        REG_TARGET_Y        = 3'd1,
        REG_ALIGN_TOLERANCE = 3'd2,
        REG_ARRIVE_DISTANCE = 3'd3,
        REG_CRUISE_SPEED    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in_item;

    typedef struct packed {
        logic signed [18:0] angular_rate;
        logic        [15:0] linear_speed;
    } t_out_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] yaw_y;
        logic signed [NUM_W-1:0] yaw_x;
        logic signed [NUM_W-1:0] brg_y;
        logic signed [NUM_W-1:0] brg_x;
        logic                    far;
    } t_prep;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] bearing;
        logic                    far;
    } t_angles;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 35'sd843314856;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043836;
            5'd3:  v = 35'sd133525158;
            5'd4:  v = 35'sd67021686;
            5'd5:  v = 35'sd33543515;
            5'd6:  v = 35'sd16775850;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194282;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048575;
            5'd11: v = 35'sd524287;
            5'd12: v = 35'sd262143;
            5'd13: v = 35'sd131071;
            5'd14: v = 35'sd65535;
            5'd15: v = 35'sd32767;
            5'd16: v = 35'sd16383;
            5'd17: v = 35'sd8191;
            5'd18: v = 35'sd4095;
            5'd19: v = 35'sd2047;
            5'd20: v = 35'sd1023;
            5'd21: v = 35'sd511;
            5'd22: v = 35'sd255;
            5'd23: v = 35'sd127;
            5'd24: v = 35'sd63;
            5'd25: v = 35'sd31;
            5'd26: v = 35'sd15;
            5'd27: v = 35'sd8;
            5'd28: v = 35'sd4;
            5'd29: v = 35'sd2;
            5'd30: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/gtp_front.sv
`default_nettype none
module gtp_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire gtp_pkg::t_in_item     i_item,
    input  wire logic signed [31:0]    i_target_x,
    input  wire logic signed [31:0]    i_target_y,
    input  wire logic        [47:0]    i_arrive_sq,
    output logic                       o_valid,
    output gtp_pkg::t_prep             o_prep
);

    // stage 1: offsets to target, hold quaternion
    logic                r1_v;
    logic signed [15:0]  r1_qx, r1_qy, r1_qz, r1_qw;
    logic signed [32:0]  r1_dx, r1_dy;

    // stage 2: products
    logic                r2_v;
    logic signed [31:0]  r2_wz, r2_xy, r2_ww, r2_xx, r2_yy, r2_zz;
    logic        [48:0]  r2_dx2, r2_dy2;
    logic                r2_near;
    logic signed [32:0]  r2_dx, r2_dy;

    // stage 3: sums and distance test
    logic                r3_v;
    gtp_pkg::t_prep      r3_prep;

    logic signed [32:0]  n_dx, n_dy;
    logic signed [24:0]  dx_lo, dy_lo;
    logic signed [49:0]  dx_sq, dy_sq;
    logic                n_near;
    logic signed [gtp_pkg::NUM_W-1:0] sum_a, yn, yd;
    logic        [49:0]  sq_sum;

    assign n_dx  = 33'(i_target_x) - 33'(i_item.pos_x);
    assign n_dy  = 33'(i_target_y) - 33'(i_item.pos_y);
    assign dx_lo = r1_dx[24:0];
    assign dy_lo = r1_dy[24:0];
    assign dx_sq = dx_lo * dx_lo;
    assign dy_sq = dy_lo * dy_lo;
    assign n_near = (r1_dx > -33'sd16777216) && (r1_dx < 33'sd16777216) &&
                    (r1_dy > -33'sd16777216) && (r1_dy < 33'sd16777216);

    assign sum_a  = gtp_pkg::NUM_W'(r2_wz) + gtp_pkg::NUM_W'(r2_xy);
    assign yn     = sum_a <<< 1;
    assign yd     = gtp_pkg::NUM_W'(r2_ww) + gtp_pkg::NUM_W'(r2_xx)
                  - gtp_pkg::NUM_W'(r2_yy) - gtp_pkg::NUM_W'(r2_zz);
    assign sq_sum = 50'(r2_dx2) + 50'(r2_dy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_qx <= i_item.quat_x;
        r1_qy <= i_item.quat_y;
        r1_qz <= i_item.quat_z;
        r1_qw <= i_item.quat_w;
        r1_dx <= n_dx;
        r1_dy <= n_dy;

        r2_wz   <= r1_qw * r1_qz;
        r2_xy   <= r1_qx * r1_qy;
        r2_ww   <= r1_qw * r1_qw;
        r2_xx   <= r1_qx * r1_qx;
        r2_yy   <= r1_qy * r1_qy;
        r2_zz   <= r1_qz * r1_qz;
        r2_dx2  <= dx_sq[48:0];
        r2_dy2  <= dy_sq[48:0];
        r2_near <= n_near;
        r2_dx   <= r1_dx;
        r2_dy   <= r1_dy;

        r3_prep.yaw_y <= yn;
        r3_prep.yaw_x <= yd;
        r3_prep.brg_y <= gtp_pkg::NUM_W'(r2_dy);
        r3_prep.brg_x <= gtp_pkg::NUM_W'(r2_dx);
        r3_prep.far   <= !r2_near || (sq_sum >= {2'b00, i_arrive_sq});
    end

    assign o_valid = r3_v;
    assign o_prep  = r3_prep;

endmodule
`default_nettype wire

>>> rtl/core/gtp_cordic.sv
`default_nettype none
module gtp_cordic (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire gtp_pkg::t_prep   i_prep,
    output logic                  o_valid,
    output gtp_pkg::t_angles      o_angles
);

    typedef struct packed {
        logic signed [gtp_pkg::VEC_W-1:0] x;
        logic signed [gtp_pkg::VEC_W-1:0] y;
        logic signed [gtp_pkg::ANG_W-1:0] z;
        logic                             zero;
    } t_lane;

    typedef struct packed {
        t_lane yaw;
        t_lane brg;
        logic  far;
    } t_cpipe;

    // fold left half-plane onto the right one, seed angle with +/-pi
    function automatic t_lane prerotate(input logic signed [gtp_pkg::NUM_W-1:0] y,
                                        input logic signed [gtp_pkg::NUM_W-1:0] x);
        t_lane l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            l.x = -gtp_pkg::VEC_W'(x);
            l.y = -gtp_pkg::VEC_W'(y);
            l.z = (y >= 0) ? gtp_pkg::PI_Q30 : -gtp_pkg::PI_Q30;
        end else begin
            l.x = gtp_pkg::VEC_W'(x);
            l.y = gtp_pkg::VEC_W'(y);
            l.z = '0;
        end
        return l;
    endfunction

    function automatic t_lane rotate(input t_lane l, input int sh);
        t_lane r;
        logic signed [gtp_pkg::VEC_W-1:0] xs, ys;
        logic signed [gtp_pkg::ANG_W-1:0] a;
        xs = l.x >>> sh;
        ys = l.y >>> sh;
        a  = gtp_pkg::atan_q30(5'(sh));
        r.zero = l.zero;
        if (l.y > 0) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + a;
        end else begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - a;
        end
        return r;
    endfunction

    t_cpipe r_pipe [0:gtp_pkg::CORDIC_STEPS];
    logic   r_vld  [0:gtp_pkg::CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= gtp_pkg::CORDIC_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= gtp_pkg::CORDIC_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe[0].yaw <= prerotate(i_prep.yaw_y, i_prep.yaw_x);
        r_pipe[0].brg <= prerotate(i_prep.brg_y, i_prep.brg_x);
        r_pipe[0].far <= i_prep.far;
        for (int k = 1; k <= gtp_pkg::CORDIC_STEPS; k++) begin
            r_pipe[k].yaw <= rotate(r_pipe[k-1].yaw, k - 1);
            r_pipe[k].brg <= rotate(r_pipe[k-1].brg, k - 1);
            r_pipe[k].far <= r_pipe[k-1].far;
        end
    end

    assign o_valid          = r_vld[gtp_pkg::CORDIC_STEPS];
    assign o_angles.yaw     = r_pipe[gtp_pkg::CORDIC_STEPS].yaw.zero ? '0
                            : r_pipe[gtp_pkg::CORDIC_STEPS].yaw.z;
    assign o_angles.bearing = r_pipe[gtp_pkg::CORDIC_STEPS].brg.zero ? '0
                            : r_pipe[gtp_pkg::CORDIC_STEPS].brg.z;
    assign o_angles.far     = r_pipe[gtp_pkg::CORDIC_STEPS].far;

endmodule
`default_nettype wire

>>> rtl/core/go_to_point_heading_controller_unit.sv
// Channel   Ports                                   Transfer when
// -------   -------------------------------------   ---------------------------------
// sample    start, busy, i_item                     start high and busy low at clk edge
// command   o_strobe, o_result                      o_strobe high (one cycle, no stall)
// config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready high
//           prdata, pready
//
// Samples pass the front stages, the CORDIC prerotation and iteration stages and the
// output stages on the way to o_strobe; one sample may start in every cycle.
// busy is always low and pready always high.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// The command side cannot stall: each result shows for exactly one cycle.
`default_nettype none
module go_to_point_heading_controller_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire gtp_pkg::t_in_item    i_item,
    output logic                      o_strobe,
    output gtp_pkg::t_out_item        o_result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    // configuration registers
    logic signed [31:0] r_target_x, r_target_y;
    logic        [15:0] r_align_tol;
    logic        [23:0] r_arrive_dist;
    logic        [15:0] r_cruise_speed;
    // squared arrival distance, refreshed in the cycle after a write
    logic        [47:0] r_arrive_sq;

    logic               cfg_wr;
    gtp_pkg::t_reg_idx  reg_idx;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = gtp_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x     <= -32'sd196608;
            r_target_y     <= -32'sd98304;
            r_align_tol    <= 16'd655;
            r_arrive_dist  <= 24'd6554;
            r_cruise_speed <= 16'd13107;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                gtp_pkg::REG_TARGET_X:        r_target_x     <= pwdata;
                gtp_pkg::REG_TARGET_Y:        r_target_y     <= pwdata;
                gtp_pkg::REG_ALIGN_TOLERANCE: r_align_tol    <= pwdata[15:0];
                gtp_pkg::REG_ARRIVE_DISTANCE: r_arrive_dist  <= pwdata[23:0];
                gtp_pkg::REG_CRUISE_SPEED:    r_cruise_speed <= pwdata[15:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_arrive_sq <= r_arrive_dist * r_arrive_dist;
    end

    always_comb begin
        unique case (reg_idx)
            gtp_pkg::REG_TARGET_X:        prdata = r_target_x;
            gtp_pkg::REG_TARGET_Y:        prdata = r_target_y;
            gtp_pkg::REG_ALIGN_TOLERANCE: prdata = {16'd0, r_align_tol};
            gtp_pkg::REG_ARRIVE_DISTANCE: prdata = {8'd0, r_arrive_dist};
            gtp_pkg::REG_CRUISE_SPEED:    prdata = {16'd0, r_cruise_speed};
            default:                      prdata = '0;
        endcase
    end

    // front stages: offsets, products, yaw operands and distance test
    logic               front_v;
    gtp_pkg::t_prep     front_prep;

    gtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_item      (i_item),
        .i_target_x  (r_target_x),
        .i_target_y  (r_target_y),
        .i_arrive_sq (r_arrive_sq),
        .o_valid     (front_v),
        .o_prep      (front_prep)
    );

    // two lockstep CORDIC lanes: yaw and bearing
    logic               cor_v;
    gtp_pkg::t_angles   cor_ang;

    gtp_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_v),
        .i_prep   (front_prep),
        .o_valid  (cor_v),
        .o_angles (cor_ang)
    );

    // heading error: halve and round Q30 difference to Q16
    logic signed [gtp_pkg::ANG_W+1:0] diff;
    logic signed [gtp_pkg::ANG_W+1:0] diff_sh;
    logic                r_f1_v;
    logic signed [20:0]  r_f1_ang;
    logic                r_f1_far;
    logic        [20:0]  mag;
    logic                aligned;
    logic                r_out_v;
    gtp_pkg::t_out_item  r_out;

    assign diff    = (gtp_pkg::ANG_W+2)'(cor_ang.bearing) - (gtp_pkg::ANG_W+2)'(cor_ang.yaw)
                   + (gtp_pkg::ANG_W+2)'(16384);
    assign diff_sh = diff >>> 15;
    assign mag     = r_f1_ang[20] ? 21'(-r_f1_ang) : 21'(r_f1_ang);
    assign aligned = mag < {5'd0, r_align_tol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_f1_v  <= cor_v;
            r_out_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_ang <= diff_sh[20:0];
        r_f1_far <= cor_ang.far;
        r_out.angular_rate <= r_f1_ang[18:0];
        r_out.linear_speed <= (aligned && r_f1_far) ? r_cruise_speed : 16'd0;
    end

    assign o_strobe = r_out_v;
    assign o_result = r_out;

    // every accepted sample later gives its result on o_strobe
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(gtp_pkg::LATENCY) o_strobe)
        else $error("result missing after accepted sample");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, gtp_pkg::LATENCY))
        else $error("result without accepted sample");

    a_speed_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.linear_speed == 16'd0 ||
                      o_result.linear_speed == r_cruise_speed))
        else $error("linear speed neither zero nor cruise speed");

endmodule
`default_nettype wire

>>> test/tb_heading_checker.sv
`default_nettype none
module tb_heading_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire gtp_pkg::t_in_item     i_item,
    input  wire logic                  i_strobe,
    input  wire gtp_pkg::t_out_item    i_result,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [4:0]            i_paddr,
    input  wire logic [31:0]           i_pwdata,
    output int                         o_fail_cnt,
    output int                         o_pending,
    output int                         o_cmd_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_RAD_Q30 = 64'sd3373259426;

    longint goal_x, goal_y, align_tol, arrive_dist, cruise;
    gtp_pkg::t_out_item cmd_q[$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        longint tab [0:31] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
            31, 15, 8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    // vectoring rotation toward the x axis; returns angle in Q30 radians
    function automatic longint vec_angle(longint y, longint x);
        longint base, z, xs, ys;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < gtp_pkg::CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z += arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z -= arctan_step(i);
            end
        end
        return base + z;
    endfunction

    function automatic gtp_pkg::t_out_item steer_command(gtp_pkg::t_in_item it);
        longint qx, qy, qz, qw, yaw, dx, dy, brg, ang, mag;
        bit far;
        gtp_pkg::t_out_item r;
        qx = it.quat_x;
        qy = it.quat_y;
        qz = it.quat_z;
        qw = it.quat_w;
        yaw = vec_angle(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
        dx = goal_x - longint'(it.pos_x);
        dy = goal_y - longint'(it.pos_y);
        brg = vec_angle(dy, dx);
        ang = floor_shift(brg - yaw + (64'sd1 << 14), 15);
        mag = ang < 0 ? -ang : ang;
        if (dx >= (64'sd1 << 24) || dx <= -(64'sd1 << 24)
            || dy >= (64'sd1 << 24) || dy <= -(64'sd1 << 24)) begin
            far = 1'b1;
        end else begin
            far = (dx * dx + dy * dy) >= arrive_dist * arrive_dist;
        end
        r.angular_rate = ang[18:0];
        r.linear_speed = (mag < align_tol && far) ? cruise[15:0] : 16'd0;
        return r;
    endfunction

    assign o_pending = cmd_q.size();

    always @(posedge i_clk) begin
        gtp_pkg::t_out_item want;
        int errs;
        if (!i_rst_n) begin
            goal_x <= -196608;
            goal_y <= -98304;
            align_tol <= 655;
            arrive_dist <= 6554;
            cruise <= 13107;
            cmd_q.delete();
            o_fail_cnt <= 0;
            o_cmd_cnt <= 0;
        end else begin
            errs = 0;
            if (i_strobe) begin
                o_cmd_cnt <= o_cmd_cnt + 1;
                if (cmd_q.size() == 0) begin
                    $error("command with no sample pending: %h", i_result);
                    errs++;
                end else begin
                    want = cmd_q.pop_front();
                    if (want.angular_rate !== i_result.angular_rate) begin
                        $error("angular_rate expected %0d got %0d",
                               want.angular_rate, i_result.angular_rate);
                        errs++;
                    end
                    if (want.linear_speed !== i_result.linear_speed) begin
                        $error("linear_speed expected %0d got %0d",
                               want.linear_speed, i_result.linear_speed);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_cnt <= o_fail_cnt + errs;
            if (i_start && !i_busy) cmd_q.push_back(steer_command(i_item));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (gtp_pkg::t_reg_idx'(i_paddr[4:2]))
                    gtp_pkg::REG_TARGET_X:        goal_x <= longint'(signed'(i_pwdata));
                    gtp_pkg::REG_TARGET_Y:        goal_y <= longint'(signed'(i_pwdata));
                    gtp_pkg::REG_ALIGN_TOLERANCE: align_tol <= i_pwdata[15:0];
                    gtp_pkg::REG_ARRIVE_DISTANCE: arrive_dist <= i_pwdata[23:0];
                    gtp_pkg::REG_CRUISE_SPEED:    cruise <= i_pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    gtp_pkg::t_in_item i_item = '0;
    logic o_strobe;
    gtp_pkg::t_out_item o_result;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_cnt, pending, cmd_cnt;
    int cycle = 0;
    int gap_pct = 8;
    bit sending;

    // 10 ns clock, two half periods
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop if the handshakes ever hang
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    go_to_point_heading_controller_unit u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_strobe, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    tb_heading_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_item,
        .i_strobe(o_strobe), .i_result(o_result), .i_psel(psel),
        .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_cnt(fail_cnt),
        .o_pending(pending), .o_cmd_cnt(cmd_cnt)
    );

    // setup cycle, then access cycle held until pready
    task automatic reg_write(gtp_pkg::t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drain every pending command, then wait longer than the pipeline latency
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (gtp_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    // hold start until a transfer happens; random idle before it
    task automatic send(gtp_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        // drop start at the next falling edge unless another send raises it
        fork
            begin
                @(negedge i_clk);
                #1 if (!sending) start <= 1'b0;
            end
        join_none
    endtask

    function automatic logic signed [15:0] quat_rand();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(32768)) - 16384);
            2: return 16'(int'($urandom_range(1024)) - 512);
            default: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        endcase
    endfunction

    function automatic logic signed [31:0] pos_rand(logic signed [31:0] goal);
        case ($urandom_range(4))
            0: return 32'($urandom);
            1: return goal + 32'(int'($urandom_range(16384)) - 8192);
            2: return goal;
            default: return 32'(int'($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic gtp_pkg::t_in_item rand_sample(logic signed [31:0] gx,
                                                      logic signed [31:0] gy);
        gtp_pkg::t_in_item it;
        it.pos_x = pos_rand(gx);
        it.pos_y = $urandom_range(9) == 0 ? gy : pos_rand(gy);
        it.quat_x = quat_rand();
        it.quat_y = quat_rand();
        it.quat_z = quat_rand();
        it.quat_w = quat_rand();
        return it;
    endfunction

    function automatic gtp_pkg::t_in_item mk(int px, int py, int qx, int qy, int qz, int qw);
        gtp_pkg::t_in_item it;
        it.pos_x = px;
        it.pos_y = py;
        it.quat_x = 16'(qx);
        it.quat_y = 16'(qy);
        it.quat_z = 16'(qz);
        it.quat_w = 16'(qw);
        return it;
    endfunction

    // one random phase under a given register set
    task automatic rand_phase(int n, logic signed [31:0] gx, logic signed [31:0] gy);
        sending = 1'b1;
        for (int i = 0; i < n; i++) begin
            send(rand_sample(gx, gy));
        end
        sending = 1'b0;
    endtask

    logic signed [31:0] gx, gy;

    initial begin
        sending = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset goal, target behind, on target, zero quaternion, extremes
        gap_pct = 0;
        sending = 1'b1;
        send(mk(-196608, -98304, 0, 0, 0, 16384));
        send(mk(0, -98304, 0, 0, 0, 16384));
        send(mk(-400000, -98304, 0, 0, 0, 0));
        send(mk(-196608, -98304, 0, 0, 0, 0));
        send(mk(-196608 + 3000, -98304, 0, 0, 16384, 0));
        send(mk(-196608, -98304 + 6554, 0, 0, 0, 16384));
        send(mk(-196608, -98304 + 6553, 0, 0, 0, 16384));
        send(mk(32'sh7fffffff, 32'sh7fffffff, 16384, 16384, 16384, 16384));
        send(mk(32'sh80000000, 32'sh80000000, -16384, -16384, -16384, -16384));
        send(mk(32'sh80000000, 32'sh7fffffff, 32767, -32768, 32767, -32768));
        send(mk(0, 0, -1, -1, -1, -1));
        send(mk(-196608 + 20000, -98304, 0, 0, 16384, 16384));
        send(mk(-196608 - 20000, -98304 + 1, 0, 0, -16384, 16384));
        send(mk(-196608 - 20000, -98304 - 1, 0, 16384, 0, 0));
        send(mk(123456, -654321, 100, -200, 300, -400));
        sending = 1'b0;
        drain();

        // extremes of every register, then random settings
        reg_write(gtp_pkg::REG_TARGET_X, 32'h7fffffff);
        reg_write(gtp_pkg::REG_TARGET_Y, 32'h80000000);
        reg_write(gtp_pkg::REG_ALIGN_TOLERANCE, 32'hffffffff);
        reg_write(gtp_pkg::REG_ARRIVE_DISTANCE, 32'hffffffff);
        reg_write(gtp_pkg::REG_CRUISE_SPEED, 32'hffffffff);
        rand_phase(200, 32'h7fffffff, 32'h80000000);
        drain();

        reg_write(gtp_pkg::REG_TARGET_X, 32'h0);
        reg_write(gtp_pkg::REG_TARGET_Y, 32'h0);
        reg_write(gtp_pkg::REG_ALIGN_TOLERANCE, 32'h0);
        reg_write(gtp_pkg::REG_ARRIVE_DISTANCE, 32'h0);
        reg_write(gtp_pkg::REG_CRUISE_SPEED, 32'h0);
        rand_phase(150, 0, 0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            gap_pct = ph < 2 ? 8 : (ph < 4 ? 86 : 0);
            gx = $urandom_range(1) ? 32'($urandom) : 32'(int'($urandom_range(400000)) - 200000);
            gy = $urandom_range(1) ? 32'($urandom) : 32'(int'($urandom_range(400000)) - 200000);
            reg_write(gtp_pkg::REG_TARGET_X, gx);
            reg_write(gtp_pkg::REG_TARGET_Y, gy);
            reg_write(gtp_pkg::REG_ALIGN_TOLERANCE,
                      $urandom_range(1) ? $urandom : $urandom_range(60000));
            reg_write(gtp_pkg::REG_ARRIVE_DISTANCE,
                      $urandom_range(1) ? $urandom : $urandom_range(20000));
            reg_write(gtp_pkg::REG_CRUISE_SPEED, $urandom);
            rand_phase(ph == 4 ? 500 : 180, gx, gy);
            // sender pause: wait out every command before the next setting
            drain();
        end

        drain();
        $display("Covered %0d steering commands over eight register settings,", cmd_cnt);
        $display("including register extremes, targets behind and on the goal.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
